/* design/tamb_pkg.sv */
// Shared constants and controller/datapath interface types for the tree mask builder.
package tamb_pkg;

  localparam int unsigned MaxNodes    = 64;
  localparam int unsigned MaxHistory  = 1984;
  localparam int unsigned RowWordsMax = 32;
  localparam int unsigned WordBits    = 64;

  localparam int unsigned NodeW   = 6;
  localparam int unsigned LinkW   = 7;
  localparam int unsigned CountW  = 7;
  localparam int unsigned HistW   = 11;
  localparam int unsigned WIdxW   = 5;
  localparam int unsigned RowLenW = 12;
  localparam int unsigned WordsW  = 6;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  localparam logic RegHistory   = 1'b0;
  localparam logic RegNodeCount = 1'b1;

  typedef struct packed {
    logic wr;      // store a parent link
    logic start;   // load walk start, clear marks
    logic step;    // check current node, mark it, read its link
    logic follow;  // move to the link just read
    logic emit;    // load the next row word into the output register
  } tamb_cmd_t;

  typedef struct packed {
    logic walk_end;   // current node stops the walk
    logic self_loop;  // link read equals current node
    logic out_free;   // output register can take a word this cycle
    logic last_word;  // word being built is the final one
  } tamb_status_t;

endpackage

/* design/tamb_ctrl.sv */
// Controller state machine: sequences writes, the ancestor walk and row emission.
module tamb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  kind_i,
  output logic                  in_stall_o,
  input  tamb_pkg::tamb_status_t status_i,
  output tamb_pkg::tamb_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (kind_i == tamb_pkg::KindQuery) begin
            cmd_o.start = 1'b1;
            state_d     = StWalk;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      StWalk: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.walk_end ? StEmit : StWait;
      end
      StWait: begin
        // read data of the marked node is now registered
        if (status_i.self_loop) begin
          state_d = StEmit;
        end else begin
          cmd_o.follow = 1'b1;
          state_d      = StWalk;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_word) state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/tamb_dp.sv */
// Datapath: config registers, parent link memory, walk registers, row word builder, output.
module tamb_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic                                   cfg_index_i,
  input  logic [tamb_pkg::HistW-1:0]             cfg_data_i,
  input  logic [tamb_pkg::NodeW-1:0]             node_i,
  input  logic signed [tamb_pkg::LinkW-1:0]      parent_i,
  input  tamb_pkg::tamb_cmd_t                    cmd_i,
  output tamb_pkg::tamb_status_t                 status_o,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [tamb_pkg::WordBits-1:0]          mask_word_o,
  output logic [tamb_pkg::WIdxW-1:0]             word_index_o,
  output logic                                   last_o,
  output logic                                   walk_broken_o
);

  localparam int unsigned WB = tamb_pkg::WordBits;

  // configuration
  logic [tamb_pkg::HistW-1:0]  hist_q;
  logic [tamb_pkg::CountW-1:0] ncount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '0;
      ncount_q <= tamb_pkg::CountW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tamb_pkg::RegHistory:   hist_q   <= cfg_data_i;
        tamb_pkg::RegNodeCount: ncount_q <= cfg_data_i[tamb_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  logic [tamb_pkg::CountW-1:0] n_eff;
  logic [tamb_pkg::HistW-1:0]  h_eff;

  always_comb begin
    if (ncount_q == '0) begin
      n_eff = tamb_pkg::CountW'(1);
    end else if (ncount_q > tamb_pkg::CountW'(tamb_pkg::MaxNodes)) begin
      n_eff = tamb_pkg::CountW'(tamb_pkg::MaxNodes);
    end else begin
      n_eff = ncount_q;
    end
    if (hist_q > tamb_pkg::HistW'(tamb_pkg::MaxHistory)) begin
      h_eff = tamb_pkg::HistW'(tamb_pkg::MaxHistory);
    end else begin
      h_eff = hist_q;
    end
  end

  // parent link memory
  logic [tamb_pkg::LinkW-1:0] link_mem [tamb_pkg::MaxNodes];
  logic [tamb_pkg::LinkW-1:0] rd_q;

  logic signed [tamb_pkg::LinkW-1:0] p_q;
  logic [tamb_pkg::CountW-1:0]       visits_q;
  logic [WB-1:0]                     vis_q;
  logic                              broken_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) link_mem[node_i] <= parent_i;
    if (cmd_i.step) rd_q <= link_mem[p_q[tamb_pkg::NodeW-1:0]];
  end

  logic p_neg, p_over, at_limit;
  assign p_neg    = p_q[tamb_pkg::LinkW-1];
  assign p_over   = {1'b0, p_q[tamb_pkg::NodeW-1:0]} >= n_eff;
  assign at_limit = visits_q >= n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q      <= '0;
      visits_q <= '0;
      vis_q    <= '0;
      broken_q <= 1'b0;
    end else if (cmd_i.start) begin
      p_q      <= {1'b0, node_i};
      visits_q <= '0;
      vis_q    <= '0;
      broken_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (!p_neg) begin
        if (p_over || at_limit) begin
          broken_q <= 1'b1;
        end else begin
          vis_q[p_q[tamb_pkg::NodeW-1:0]] <= 1'b1;
          visits_q <= visits_q + tamb_pkg::CountW'(1);
        end
      end
    end else if (cmd_i.follow) begin
      p_q <= rd_q;
    end
  end

  // row word builder
  logic [tamb_pkg::WIdxW-1:0]   w_q;
  logic [tamb_pkg::RowLenW-1:0] total;
  logic [tamb_pkg::RowLenW:0]   total_up;
  logic [tamb_pkg::WordsW-1:0]  words;
  logic [tamb_pkg::WordsW-1:0]  w_next;
  logic signed [tamb_pkg::RowLenW-1:0] d;
  logic signed [tamb_pkg::RowLenW-1:0] nd;
  logic [WB-1:0] hist_bits, tree_bits, word;

  always_comb begin
    total    = tamb_pkg::RowLenW'(h_eff) + tamb_pkg::RowLenW'(n_eff);
    total_up = {1'b0, total} + (tamb_pkg::RowLenW + 1)'(WB - 1);
    if (total_up[tamb_pkg::RowLenW:6] > (tamb_pkg::RowLenW - 5)'(tamb_pkg::RowWordsMax)) begin
      words = tamb_pkg::WordsW'(tamb_pkg::RowWordsMax);
    end else begin
      words = total_up[6 +: tamb_pkg::WordsW];
    end
    w_next = {1'b0, w_q} + tamb_pkg::WordsW'(1);

    // offset of the first tree position relative to this word's base
    d  = $signed(tamb_pkg::RowLenW'(h_eff)) - $signed({1'b0, w_q, 6'b0});
    nd = -d;
    if (d[tamb_pkg::RowLenW-1]) begin
      hist_bits = '0;
      if (nd < $signed(tamb_pkg::RowLenW'(WB))) begin
        tree_bits = vis_q >> nd[5:0];
      end else begin
        tree_bits = '0;
      end
    end else if (d >= $signed(tamb_pkg::RowLenW'(WB))) begin
      hist_bits = '1;
      tree_bits = '0;
    end else begin
      hist_bits = ~({WB{1'b1}} << d[5:0]);
      tree_bits = vis_q << d[5:0];
    end
    word = hist_bits | tree_bits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else if (cmd_i.start) begin
      w_q <= '0;
    end else if (cmd_i.emit) begin
      w_q <= w_next[tamb_pkg::WIdxW-1:0];
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mask_word_o   <= word;
      word_index_o  <= w_q;
      last_o        <= (w_next == words);
      walk_broken_o <= broken_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.walk_end  = p_neg || p_over || at_limit;
  assign status_o.self_loop = (rd_q == p_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.last_word = (w_next == words);

endmodule

/* design/tree_attention_mask_builder.sv */
// Top level of the tree attention mask row builder.
//
// Input channel (in_valid_i / in_stall_o) takes one word per item: kind_i = 0
// stores parent_i as the parent link of node_i, kind_i = 1 queries the mask
// row of node_i. A word is taken when in_valid_i is high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i) gives each result as 64-bit row
// words, word_index_o counting up from 0 and last_o on the final word.
// Config channel (cfg_valid_i / cfg_ready_o, always ready) writes
// history_length (index 0) or node_count (index 1); write only while idle.
// A write item is stored without leaving idle. A query walks the parent
// links, with a walk state and a wait state per followed link (link memory
// read is registered), then emits one word per cycle while the receiver
// takes them. One item is in flight at a time; the next is taken once the
// last word sits in the output register.
// When out_stall_i holds, the output register keeps its word and emission
// pauses. Reset clears the controller, the output valid and the config
// registers (history 0, node count 1); the link memory is undefined until
// written.
module tree_attention_mask_builder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [tamb_pkg::HistW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [tamb_pkg::NodeW-1:0]        node_i,
  input  logic signed [tamb_pkg::LinkW-1:0] parent_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tamb_pkg::WordBits-1:0]     mask_word_o,
  output logic [tamb_pkg::WIdxW-1:0]        word_index_o,
  output logic                              last_o,
  output logic                              walk_broken_o
);

  tamb_pkg::tamb_cmd_t    cmd;
  tamb_pkg::tamb_status_t status;

  assign cfg_ready_o = 1'b1;

  tamb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tamb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .node_i        (node_i),
    .parent_i      (parent_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .mask_word_o   (mask_word_o),
    .word_index_o  (word_index_o),
    .last_o        (last_o),
    .walk_broken_o (walk_broken_o)
  );

endmodule
